### design/positional_list_store_unit_defines.svh
// Assertion macros for the list store control module, plsu_ctrl.
// Each macro expects clk and rst_n in scope of the module that uses it.
`ifndef POSITIONAL_LIST_STORE_UNIT_DEFINES_SVH
`define POSITIONAL_LIST_STORE_UNIT_DEFINES_SVH

// Check an implication in the same cycle.
`define PLSU_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check an implication in the next cycle.
`define PLSU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/plsu_pkg.sv
// Shared types and constants for the positional list store.
// No dependencies.
package plsu_pkg;

  localparam int ACTION_W = 2;
  localparam int POS_W    = 8;
  localparam int DATA_W   = 32;
  localparam int COUNT_W  = 7;

  // Action codes; the fourth code is unused and rejected.
  typedef enum logic [ACTION_W-1:0] {
    ACT_GET    = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_DELETE = 2'd2
  } act_t;

  // Per-cycle shift command broadcast to every cell.
  typedef struct packed {
    logic shift_up;
    logic shift_down;
  } cmd_t;

endpackage

### design/plsu_cell.sv
// One slot of the list: holds an element and trades it with its neighbors.
// Depends on plsu_pkg.
module plsu_cell import plsu_pkg::*; #(
  parameter int IDXW = 6,
  parameter int IDX  = 0
) (
  input  logic                     clk,
  input  cmd_t                     cmd,
  input  logic [IDXW-1:0]          pos_idx,
  input  logic signed [DATA_W-1:0] value,
  input  logic signed [DATA_W-1:0] prev_data,
  input  logic signed [DATA_W-1:0] next_data,
  output logic signed [DATA_W-1:0] data,
  output logic signed [DATA_W-1:0] rd_data
);

  localparam logic [IDXW-1:0] MY_IDX = IDXW'(IDX);

  logic signed [DATA_W-1:0] data_r;
  logic signed [DATA_W-1:0] data_nxt;
  logic                     at_pos;
  logic                     above_pos;

  assign at_pos    = (pos_idx == MY_IDX);
  assign above_pos = (MY_IDX >= pos_idx);

  // Take the new value, the lower neighbor or the upper neighbor
  always_comb begin
    data_nxt = data_r;
    if (cmd.shift_up && above_pos) begin
      data_nxt = at_pos ? value : prev_data;
    end else if (cmd.shift_down && above_pos) begin
      data_nxt = next_data;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  // Drive the read bus only when addressed
  assign data    = data_r;
  assign rd_data = at_pos ? data_r : '0;

endmodule

### design/plsu_ctrl.sv
// Action decode, range checks, element count and result register.
// Depends on plsu_pkg and positional_list_store_unit_defines.svh.
`include "positional_list_store_unit_defines.svh"
module plsu_ctrl import plsu_pkg::*; #(
  parameter int CAPACITY = 64,
  parameter int IDXW     = 6,
  parameter int FW       = 7
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [ACTION_W-1:0]      action,
  input  logic [POS_W-1:0]         position,
  input  logic signed [DATA_W-1:0] rd_data,
  output cmd_t                     cmd,
  output logic [IDXW-1:0]          pos_idx,
  output logic                     out_valid,
  output logic                     out_status,
  output logic signed [DATA_W-1:0] out_element,
  output logic [COUNT_W-1:0]       out_count
);

  localparam int CW = ((FW > POS_W) ? FW : POS_W) + 1;

  logic [FW-1:0]            fill_r, fill_nxt;
  logic                     valid_r, valid_nxt;
  logic                     status_r, status_nxt;
  logic signed [DATA_W-1:0] element_r, element_nxt;
  logic [COUNT_W-1:0]       count_r, count_nxt;
  logic [CW-1:0]            pos_x;
  logic [CW-1:0]            fill_x;
  logic                     pos_nz;
  logic                     rd_ok;
  logic                     ins_ok;
  logic [POS_W-1:0]         pos_m1;

  assign pos_x  = CW'(position);
  assign fill_x = CW'(fill_r);
  assign pos_nz = (position != '0);
  assign rd_ok  = pos_nz && (pos_x <= fill_x);
  assign ins_ok = pos_nz && (fill_x < CW'(CAPACITY)) && (pos_x <= fill_x + CW'(1));
  assign pos_m1 = position - POS_W'(1);
  assign pos_idx = IDXW'(pos_m1);

  // Decode the action and form the result
  always_comb begin
    cmd         = '0;
    fill_nxt    = fill_r;
    status_nxt  = 1'b1;
    element_nxt = '0;
    if (start) begin
      unique case (act_t'(action))
        ACT_GET: begin
          if (rd_ok) begin
            status_nxt  = 1'b0;
            element_nxt = rd_data;
          end
        end
        ACT_INSERT: begin
          if (ins_ok) begin
            status_nxt   = 1'b0;
            cmd.shift_up = 1'b1;
            fill_nxt     = fill_r + FW'(1);
          end
        end
        ACT_DELETE: begin
          if (rd_ok) begin
            status_nxt     = 1'b0;
            element_nxt    = rd_data;
            cmd.shift_down = 1'b1;
            fill_nxt       = fill_r - FW'(1);
          end
        end
        default: begin
          status_nxt = 1'b1;
        end
      endcase
    end
    valid_nxt = start;
    count_nxt = COUNT_W'(fill_nxt);
  end

  // Hold the count and the one-cycle result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r  <= '0;
      valid_r <= 1'b0;
    end else begin
      fill_r  <= fill_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r  <= status_nxt;
    element_r <= element_nxt;
    count_r   <= count_nxt;
  end

  assign out_valid   = valid_r;
  assign out_status  = status_r;
  assign out_element = element_r;
  assign out_count   = count_r;

  `PLSU_ASSERT_NOW(a_fill_cap, 1'b1, fill_x <= CW'(CAPACITY), "fill above capacity")
  `PLSU_ASSERT_NOW(a_cmd_excl, 1'b1, !(cmd.shift_up && cmd.shift_down), "both shifts active")
  `PLSU_ASSERT_NEXT(a_ins_grow, cmd.shift_up, fill_r == $past(fill_r) + FW'(1), "insert did not grow")
  `PLSU_ASSERT_NEXT(a_err_hold, start && status_nxt, $stable(fill_r) && out_status, "error changed fill")
  `PLSU_ASSERT_NEXT(a_strobe, start, out_valid && (out_count == COUNT_W'(fill_r)), "result missing")

endmodule

### design/positional_list_store_unit.sv
// Positional list store: out_valid rises in the cycle after start, one item
// accepted every cycle; busy stays low. Every cell at or above the position
// shifts in the same cycle, so the rate does not depend on position or CAPACITY;
// a get reads through an AND-OR select over all cells. Synchronous reset empties
// the list at once; slot contents are not cleared and no item needs to wait after reset.
// Depends on plsu_pkg, plsu_cell and plsu_ctrl.
module positional_list_store_unit import plsu_pkg::*; #(
  parameter int CAPACITY = 64
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [ACTION_W-1:0]      in_action,
  input  logic [POS_W-1:0]         in_position,
  input  logic signed [DATA_W-1:0] in_value,
  output logic                     out_valid,
  output logic                     out_status,
  output logic signed [DATA_W-1:0] out_element,
  output logic [COUNT_W-1:0]       out_count
);

  localparam int IDXW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int FW   = $clog2(CAPACITY + 1);

  cmd_t                     cmd;
  logic [IDXW-1:0]          pos_idx;
  logic signed [DATA_W-1:0] slot_q [CAPACITY];
  logic signed [DATA_W-1:0] rd_q   [CAPACITY];
  logic signed [DATA_W-1:0] rd_sel;

  // Never stall: every action is accepted as soon as start is seen
  assign busy = 1'b0;

  plsu_ctrl #(
    .CAPACITY(CAPACITY),
    .IDXW    (IDXW),
    .FW      (FW)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .action     (in_action),
    .position   (in_position),
    .rd_data    (rd_sel),
    .cmd        (cmd),
    .pos_idx    (pos_idx),
    .out_valid  (out_valid),
    .out_status (out_status),
    .out_element(out_element),
    .out_count  (out_count)
  );

  // Build the chain; the ends see the new value and their own slot
  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    plsu_cell #(
      .IDXW(IDXW),
      .IDX (k)
    ) u_cell (
      .clk      (clk),
      .cmd      (cmd),
      .pos_idx  (pos_idx),
      .value    (in_value),
      .prev_data((k == 0) ? in_value : slot_q[(k == 0) ? 0 : k - 1]),
      .next_data((k == CAPACITY - 1) ? slot_q[k] : slot_q[(k == CAPACITY - 1) ? k : k + 1]),
      .data     (slot_q[k]),
      .rd_data  (rd_q[k])
    );
  end

  // Merge the read bus; at most one cell drives it
  always_comb begin
    rd_sel = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      rd_sel = rd_sel | rd_q[k];
    end
  end

endmodule
